### rtl/core/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg - heightmap box smoother shared definitions
// Widths, window geometry, register codes and the pipeline tag type.
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CNT_W        = 10;
    localparam int SMOOTH_REACH = 3;
    localparam int BOX_SIDE     = SMOOTH_REACH + 1;
    localparam int BOX_SHIFT    = $clog2(BOX_SIDE * BOX_SIDE);
    localparam int BANK_W       = $clog2(SMOOTH_REACH);
    localparam int CSUM_W       = SAMPLE_W + $clog2(BOX_SIDE);
    localparam int TOTAL_W      = CSUM_W + $clog2(BOX_SIDE);

    localparam int DEF_MAX_ROW_SAMPLES = 1024;

    localparam logic [CNT_W-1:0] GRID_RESET = CNT_W'(256);

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // per-item control carried down the pipe
    typedef struct packed {
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             emit;
        logic             smooth;
        logic             last;
    } t_tag;

endpackage

### rtl/core/heightmap_box_smoother.sv
// ----------------------------------------------------------------------------
// heightmap_box_smoother - streaming 4x4 box smoother for a height grid
// Line-buffered forward-looking box mean over a raster stream of Q8.8 samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one signed Q8.8 height
//    per request, raster order, (grid_height+1) rows of (grid_width+1) samples.
//  - Output channel (o_out_valid / i_out_ready) carries zero or one result per
//    input request: the sample three rows up and three columns left, either
//    the floored 4x4 mean (o_was_smoothed = 1) or the sample as it came in.
//    o_frame_last marks the result of the frame's final sample.
//  - Config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//    grid_width (index 0) and grid_height (index 1). Write only while idle.
//  - Throughput: one request per cycle unless stalled. Three row-store banks,
//    each with one read and one write port per cycle, set that figure.
//  - Path: an accepted request passes the input register, the column-sum
//    stage and the output register in turn before its result appears.
//  - Stall: a held result stops the column-sum stage only when that stage
//    also holds an item with a result; items that give no result pass it.
//    Once both stages are stuck, o_in_ready drops until i_out_ready returns.
//  - Reset (i_rst_n low, synchronous) clears counters, window and valid bits
//    and loads 256 into both grid registers. Row store is not cleared; entries
//    read before they are written feed no result.
// ----------------------------------------------------------------------------
module heightmap_box_smoother #(
    parameter int MAX_ROW_SAMPLES = hbs_pkg::DEF_MAX_ROW_SAMPLES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hbs_pkg::CNT_W-1:0]     i_cfg_data,
    // samples in
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [hbs_pkg::SAMPLE_W-1:0] i_height_sample,
    // results out
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hbs_pkg::CNT_W-1:0]     o_out_row,
    output logic [hbs_pkg::CNT_W-1:0]     o_out_col,
    output logic signed [hbs_pkg::SAMPLE_W-1:0] o_height_out,
    output logic                          o_was_smoothed,
    output logic                          o_frame_last
);

    localparam int AW    = $clog2(MAX_ROW_SAMPLES);
    localparam int REACH = hbs_pkg::SMOOTH_REACH;
    localparam int SIDE  = hbs_pkg::BOX_SIDE;
    localparam int CW    = hbs_pkg::CNT_W;
    localparam int BW    = hbs_pkg::BANK_W;

    localparam logic [AW-1:0] ADDR_LAST  = AW'(MAX_ROW_SAMPLES - 1);
    localparam logic [BW-1:0] BANK_LAST  = BW'(REACH - 1);
    localparam logic [CW-1:0] REACH_C    = CW'(REACH);
    localparam logic [CW-1:0] REACH_P1_C = CW'(REACH + 1);

    // ---------------------------------------------------------------- config
    logic [CW-1:0] r_grid_w;
    logic [CW-1:0] r_grid_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= hbs_pkg::GRID_RESET;
            r_grid_h <= hbs_pkg::GRID_RESET;
        end else if (i_cfg_valid) begin
            case (hbs_pkg::t_cfg_reg'(i_cfg_index))
                hbs_pkg::REG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                hbs_pkg::REG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------ pipeline control
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    hbs_pkg::t_tag r_s1_tag;
    hbs_pkg::t_tag r_s2_tag;

    logic out_free;   // output register can take a result
    logic s2_leave;   // column-sum stage hands its item on
    logic s2_free;
    logic s1_move;    // input register moves into column-sum stage
    logic in_acc;

    assign out_free = !r_out_valid || i_out_ready;
    assign s2_leave = r_s2_valid && (!r_s2_tag.emit || out_free);
    assign s2_free  = !r_s2_valid || s2_leave;
    assign s1_move  = r_s1_valid && s2_free;
    assign o_in_ready = !r_s1_valid || s2_free;
    assign in_acc   = i_in_valid && o_in_ready;

    // ---------------------------------------------------------- raster counters
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_addr, n_addr;   // column modulo row-store depth
    logic [BW-1:0] r_bank, n_bank;   // row modulo SMOOTH_REACH
    logic          row_end;
    logic          frame_end;

    assign row_end   = r_col >= r_grid_w;
    assign frame_end = row_end && (r_row >= r_grid_h);

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_addr = r_addr;
        n_bank = r_bank;
        if (in_acc) begin
            if (row_end) begin
                n_col  = '0;
                n_addr = '0;
                if (frame_end) begin
                    n_row  = '0;
                    n_bank = '0;
                end else begin
                    n_row  = r_row + CW'(1);
                    n_bank = (r_bank == BANK_LAST) ? '0 : r_bank + BW'(1);
                end
            end else begin
                n_col  = r_col + CW'(1);
                n_addr = (r_addr == ADDR_LAST) ? '0 : r_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_addr <= '0;
            r_bank <= '0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_addr <= n_addr;
            r_bank <= n_bank;
        end
    end

    // --------------------------------------------------------- stage 1 entry
    // Emit once three rows and three columns are in; smoothing needs the
    // emitted sample off the first row/column and the block off the last ones.
    hbs_pkg::t_tag in_tag;
    always_comb begin
        in_tag.row    = r_row - REACH_C;
        in_tag.col    = r_col - REACH_C;
        in_tag.emit   = (r_row >= REACH_C) && (r_col >= REACH_C);
        in_tag.smooth = (r_row >= REACH_P1_C) && (r_row < r_grid_h) &&
                        (r_col >= REACH_P1_C) && (r_col < r_grid_w);
        in_tag.last   = frame_end;
    end

    hbs_pkg::t_sample r_s1_v;
    logic [AW-1:0]    r_s1_addr;
    logic [BW-1:0]    r_s1_bank;
    // bypass for a write to the same column landing on the read edge
    logic             r_s1_fwd_hit;
    logic [BW-1:0]    r_s1_fwd_bank;
    hbs_pkg::t_sample r_s1_fwd_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_tag      <= in_tag;
            r_s1_v        <= i_height_sample;
            r_s1_addr     <= r_addr;
            r_s1_bank     <= r_bank;
            r_s1_fwd_hit  <= s1_move && (r_s1_addr == r_addr);
            r_s1_fwd_bank <= r_s1_bank;
            r_s1_fwd_val  <= r_s1_v;
        end
    end

    // ------------------------------------------------------------ row store
    // One bank per stored row; all banks read at the column, the oldest bank
    // rewritten with the new sample when the item leaves stage 1.
    hbs_pkg::t_sample r_rd [REACH];

    for (genvar k = 0; k < REACH; k++) begin : g_bank
        hbs_pkg::t_sample mem [MAX_ROW_SAMPLES];

        always_ff @(posedge i_clk) begin
            if (s1_move && (r_s1_bank == BW'(k))) begin
                mem[r_s1_addr] <= r_s1_v;
            end
            if (in_acc) begin
                r_rd[k] <= mem[r_addr];
            end
        end
    end

    // ------------------------------------------------------ column sum stage
    hbs_pkg::t_sample rd_fwd [REACH];
    logic signed [hbs_pkg::CSUM_W-1:0] col_sum;
    hbs_pkg::t_sample oldest;

    always_comb begin
        col_sum = hbs_pkg::CSUM_W'(r_s1_v);
        for (int k = 0; k < REACH; k++) begin
            rd_fwd[k] = (r_s1_fwd_hit && (r_s1_fwd_bank == BW'(k))) ?
                        r_s1_fwd_val : r_rd[k];
            col_sum   = col_sum + hbs_pkg::CSUM_W'(rd_fwd[k]);
        end
        oldest = rd_fwd[r_s1_bank];
    end

    logic signed [hbs_pkg::CSUM_W-1:0] r_csum [SIDE];
    hbs_pkg::t_sample                  r_odly [SIDE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int k = 0; k < SIDE; k++) begin
                r_csum[k] <= '0;
                r_odly[k] <= '0;
            end
        end else begin
            if (s1_move) begin
                r_s2_valid <= 1'b1;
                for (int k = 0; k < SIDE - 1; k++) begin
                    r_csum[k] <= r_csum[k+1];
                    r_odly[k] <= r_odly[k+1];
                end
                r_csum[SIDE-1] <= col_sum;
                r_odly[SIDE-1] <= oldest;
            end else if (s2_leave) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    // ------------------------------------------------------- output register
    // Floor of total/16 is an arithmetic shift; the mean always fits 16 bits.
    logic signed [hbs_pkg::TOTAL_W-1:0] box_total;
    logic signed [hbs_pkg::TOTAL_W-1:0] box_mean;
    hbs_pkg::t_sample                   res_val;

    always_comb begin
        box_total = '0;
        for (int k = 0; k < SIDE; k++) begin
            box_total = box_total + hbs_pkg::TOTAL_W'(r_csum[k]);
        end
        box_mean = box_total >>> hbs_pkg::BOX_SHIFT;
        res_val  = r_s2_tag.smooth ? box_mean[hbs_pkg::SAMPLE_W-1:0] : r_odly[0];
    end

    logic out_load;
    assign out_load = s2_leave && r_s2_tag.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    hbs_pkg::t_tag    r_out_tag;
    hbs_pkg::t_sample r_out_val;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_tag <= r_s2_tag;
            r_out_val <= res_val;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_row      = r_out_tag.row;
    assign o_out_col      = r_out_tag.col;
    assign o_height_out   = r_out_val;
    assign o_was_smoothed = r_out_tag.smooth;
    assign o_frame_last   = r_out_tag.last;

    // ------------------------------------------------------------ assertions
    a_frame_wrap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && frame_end |=> (r_row == '0) && (r_col == '0) && (r_addr == '0)
                                && (r_bank == '0))
        else $error("counters did not return to zero after frame end");

    a_bank_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank <= BANK_LAST)
        else $error("row bank index out of range");

    a_addr_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= ADDR_LAST)
        else $error("row store address out of range");

    a_smooth_inner : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_smoothed |-> (o_out_row != '0) && (o_out_col != '0))
        else $error("smoothed result on first row or column");

    a_fwd_live : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s1_move && (r_s1_addr == r_addr) |=> r_s1_fwd_hit)
        else $error("same-column bypass missed");

endmodule
